// ===== sv/dgrf_pkg.sv =====
// ----------------------------------------------------------------------------
// dgrf_pkg
// Shared types and constants of the dual raise/fall gain tracker.
// ----------------------------------------------------------------------------
package dgrf_pkg;

  localparam int unsigned GAIN_W = 24;

  // 1.0 in unsigned Q8.16
  localparam logic [GAIN_W-1:0] ONE_Q16 = 24'h01_0000;

  typedef enum logic [2:0] {
    GM_DISABLED    = 3'd0,
    GM_INDEPENDENT = 3'd1,
    GM_TOGETHER    = 3'd2,
    GM_ALTERNATE   = 3'd3,
    GM_HALF_ALT    = 3'd4
  } gain_mode_t;

  typedef enum logic [1:0] {
    FN_UPDATE = 2'd0,
    FN_LOAD   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_HOLD   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_GAIN_MODE       = 3'd0,
    REG_STEP_IS_PRODUCT = 3'd1,
    REG_RAISE_STEP      = 3'd2,
    REG_FALL_STEP       = 3'd3,
    REG_GAIN_CAP        = 3'd4
  } reg_index_t;

  // Step settings shared by both sides
  typedef struct packed {
    logic              step_is_product;
    logic [19:0]       raise_step;
    logic [16:0]       fall_step;
    logic [GAIN_W-1:0] gain_cap;
  } step_cfg_t;

endpackage

// ===== sv/dual_gain_raise_fall.sv =====
// ----------------------------------------------------------------------------
// dual_gain_raise_fall
// Buy and sell gain multipliers in Q8.16 that rise on trades and fall
// otherwise, with load and clear events and five interaction modes.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Content
// s_axis    in   s_tvalid / s_tready       tuser func, tdata hits and loads
// m_axis    out  m_tvalid / m_tready       tdata buy_gain, sell_gain
// apb       in   psel, penable, pready=1   registers at 4*index
//
// One event per cycle while the output is not stalled.
// The event is registered, then one multiply and clamp per side runs from
// the stored levels into the result register and the level registers.
// A stalled result holds while one more event waits in the input register.
// Reset sets both levels to 1.0 and the registers to their defaults.
// ----------------------------------------------------------------------------
module dual_gain_raise_fall (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] func
  input  logic [55:0] s_tdata,   // [0] buy_hit, [1] sell_hit, [25:2] load_buy_gain,
                                 // [49:26] load_sell_gain, [55:50] zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [23:0] buy_gain, [47:24] sell_gain
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dgrf_pkg::*;

  // configuration registers
  gain_mode_t        gain_mode;
  step_cfg_t         step_cfg;
  reg_index_t        reg_sel;

  // input register
  logic              in_valid;
  func_t             in_func;
  logic              in_buy_hit;
  logic              in_sell_hit;
  logic [GAIN_W-1:0] in_load_buy;
  logic [GAIN_W-1:0] in_load_sell;

  // state and result
  logic [GAIN_W-1:0] buy_level;
  logic [GAIN_W-1:0] sell_level;
  logic [GAIN_W-1:0] buy_level_next;
  logic [GAIN_W-1:0] sell_level_next;
  logic              out_valid;
  logic [GAIN_W-1:0] out_buy;
  logic [GAIN_W-1:0] out_sell;

  logic              advance;
  logic              s_accept;
  logic              buy_up;
  logic              sell_up;
  logic [GAIN_W-1:0] buy_pre;
  logic [GAIN_W-1:0] sell_pre;
  logic [GAIN_W-1:0] buy_stepped;
  logic [GAIN_W-1:0] sell_stepped;

  // --------------------------------------------------------------------------
  // APB
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_mode                <= GM_DISABLED;
      step_cfg.step_is_product <= 1'b1;
      step_cfg.raise_step      <= '0;
      step_cfg.fall_step       <= '0;
      step_cfg.gain_cap        <= '1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_GAIN_MODE:       gain_mode <= gain_mode_t'(pwdata[2:0]);
        REG_STEP_IS_PRODUCT: step_cfg.step_is_product <= pwdata[0];
        REG_RAISE_STEP:      step_cfg.raise_step <= pwdata[19:0];
        REG_FALL_STEP:       step_cfg.fall_step <= pwdata[16:0];
        REG_GAIN_CAP:        step_cfg.gain_cap <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GAIN_MODE:       prdata = 32'(gain_mode);
      REG_STEP_IS_PRODUCT: prdata = 32'(step_cfg.step_is_product);
      REG_RAISE_STEP:      prdata = 32'(step_cfg.raise_step);
      REG_FALL_STEP:       prdata = 32'(step_cfg.fall_step);
      REG_GAIN_CAP:        prdata = 32'(step_cfg.gain_cap);
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_func      <= func_t'(s_tuser);
      in_buy_hit   <= s_tdata[0];
      in_sell_hit  <= s_tdata[1];
      in_load_buy  <= s_tdata[25:2];
      in_load_sell <= s_tdata[49:26];
    end
  end

  // --------------------------------------------------------------------------
  // Mode handling before the step
  // --------------------------------------------------------------------------
  always_comb begin
    buy_up   = in_buy_hit;
    sell_up  = in_sell_hit;
    buy_pre  = buy_level;
    sell_pre = sell_level;
    unique case (gain_mode)
      GM_TOGETHER: begin
        buy_up  = in_buy_hit || in_sell_hit;
        sell_up = in_buy_hit || in_sell_hit;
      end
      GM_ALTERNATE: begin
        if (in_buy_hit) begin
          sell_pre = ONE_Q16;
        end else if (in_sell_hit) begin
          buy_pre = ONE_Q16;
        end
      end
      GM_HALF_ALT: begin
        // halve the excess over 1.0 of the opposite side
        if (in_buy_hit) begin
          sell_pre = GAIN_W'((25'(sell_level) + 25'(ONE_Q16)) >> 1);
        end else if (in_sell_hit) begin
          buy_pre = GAIN_W'((25'(buy_level) + 25'(ONE_Q16)) >> 1);
        end
      end
      default: ;
    endcase
  end

  dgrf_step u_buy_step (
    .level  (buy_pre),
    .up     (buy_up),
    .cfg    (step_cfg),
    .result (buy_stepped)
  );

  dgrf_step u_sell_step (
    .level  (sell_pre),
    .up     (sell_up),
    .cfg    (step_cfg),
    .result (sell_stepped)
  );

  always_comb begin
    unique case (in_func)
      FN_UPDATE: begin
        if (gain_mode == GM_DISABLED) begin
          buy_level_next  = ONE_Q16;
          sell_level_next = ONE_Q16;
        end else begin
          buy_level_next  = buy_stepped;
          sell_level_next = sell_stepped;
        end
      end
      FN_LOAD: begin
        buy_level_next  = in_load_buy;
        sell_level_next = in_load_sell;
      end
      FN_CLEAR: begin
        buy_level_next  = ONE_Q16;
        sell_level_next = ONE_Q16;
      end
      FN_HOLD: begin
        buy_level_next  = buy_level;
        sell_level_next = sell_level;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      buy_level  <= ONE_Q16;
      sell_level <= ONE_Q16;
      out_valid  <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        buy_level  <= buy_level_next;
        sell_level <= sell_level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_buy  <= buy_level_next;
      out_sell <= sell_level_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_sell, out_buy};

endmodule

// ===== sv/dgrf_step.sv =====
// ----------------------------------------------------------------------------
// dgrf_step
// Raise or fall of one multiplier, additive or multiplicative, with cap at
// gain_cap and floor at 1.0. Pure combinational.
// ----------------------------------------------------------------------------
module dgrf_step (
  input  logic [dgrf_pkg::GAIN_W-1:0] level,
  input  logic                        up,
  input  dgrf_pkg::step_cfg_t         cfg,
  output logic [dgrf_pkg::GAIN_W-1:0] result
);
  import dgrf_pkg::*;

  logic [20:0] raise_mult;
  logic [44:0] up_prod;
  logic [28:0] up_raw;
  logic [16:0] fall_mult;
  logic [40:0] dn_prod;
  logic [24:0] dn_raw;

  assign raise_mult = 21'(ONE_Q16) + 21'(cfg.raise_step);
  assign up_prod    = 45'(level) * 45'(raise_mult);
  assign fall_mult  = 17'(ONE_Q16) - cfg.fall_step;
  assign dn_prod    = 41'(level) * 41'(fall_mult);

  always_comb begin
    if (cfg.step_is_product) begin
      up_raw = up_prod[44:16];
    end else begin
      up_raw = 29'(level) + 29'(cfg.raise_step);
    end

    // fall candidate, forced to 1.0 when the step eats the whole value
    if (cfg.step_is_product) begin
      if (cfg.fall_step[16]) begin
        dn_raw = 25'(ONE_Q16);
      end else begin
        dn_raw = dn_prod[40:16];
      end
    end else begin
      if (24'(cfg.fall_step) >= level) begin
        dn_raw = 25'(ONE_Q16);
      end else begin
        dn_raw = 25'(level - 24'(cfg.fall_step));
      end
    end

    if (up) begin
      if (up_raw > 29'(cfg.gain_cap)) begin
        result = cfg.gain_cap;
      end else begin
        result = up_raw[GAIN_W-1:0];
      end
    end else begin
      if (dn_raw < 25'(ONE_Q16)) begin
        result = ONE_Q16;
      end else begin
        result = dn_raw[GAIN_W-1:0];
      end
    end
  end

endmodule
